// File: rtl/jvt_pkg.sv
// ----------------------------------------------------------------------------
// jvt_pkg
// shared types and codes of the json validating tokenizer
// ----------------------------------------------------------------------------
package jvt_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       endf;
        logic       ws;
        logic       dig;
        logic       lower;
        logic       hexv;
        logic [3:0] hexd;
    } item_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [7:0]  data_byte;
        logic        is_key;
        logic [6:0]  nest_level;
        logic [3:0]  error_code;
        logic [31:0] byte_offset;
        logic        last;
    } res_t;

    localparam logic [3:0] EV_OBJ_OPEN  = 4'd0;
    localparam logic [3:0] EV_OBJ_CLOSE = 4'd1;
    localparam logic [3:0] EV_ARR_OPEN  = 4'd2;
    localparam logic [3:0] EV_ARR_CLOSE = 4'd3;
    localparam logic [3:0] EV_STR_OPEN  = 4'd4;
    localparam logic [3:0] EV_STR_BYTE  = 4'd5;
    localparam logic [3:0] EV_STR_CLOSE = 4'd6;
    localparam logic [3:0] EV_NUM_CHAR  = 4'd7;
    localparam logic [3:0] EV_NUM_END   = 4'd8;
    localparam logic [3:0] EV_TRUE      = 4'd9;
    localparam logic [3:0] EV_FALSE     = 4'd10;
    localparam logic [3:0] EV_NULL      = 4'd11;
    localparam logic [3:0] EV_DOC_OK    = 4'd12;
    localparam logic [3:0] EV_ERROR     = 4'd13;

    localparam logic [3:0] ER_NONE      = 4'd0;
    localparam logic [3:0] ER_BAD_CHAR  = 4'd1;
    localparam logic [3:0] ER_BAD_ESC   = 4'd2;
    localparam logic [3:0] ER_UNICODE   = 4'd3;
    localparam logic [3:0] ER_CONTROL   = 4'd4;
    localparam logic [3:0] ER_BAD_NUM   = 4'd5;
    localparam logic [3:0] ER_BAD_LIT   = 4'd6;
    localparam logic [3:0] ER_TOO_DEEP  = 4'd7;
    localparam logic [3:0] ER_TRAILING  = 4'd8;
    localparam logic [3:0] ER_EARLY_END = 4'd9;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_LF_    = 8'h66;
    localparam logic [7:0] CH_LL     = 8'h6C;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LS     = 8'h73;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LU     = 8'h75;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [7:0] CH_BS_CODE = 8'h08;
    localparam logic [7:0] CH_FF_CODE = 8'h0C;

endpackage

// File: rtl/jvt_front.sv
// ----------------------------------------------------------------------------
// jvt_front
// input stage: classifies each text byte and holds it in a two-entry queue
// ----------------------------------------------------------------------------
module jvt_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [7:0]     s_text_byte,
    input  logic           s_end_mark,
    input  logic           s_valid,
    output logic           s_ready,
    output jvt_pkg::item_t head,
    output logic           head_valid,
    input  logic           head_pop
);
    import jvt_pkg::*;

    item_t       slot_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    item_t       cls;
    logic        push;
    logic [7:0]  c;

    always_comb begin
        cls.endf  = s_end_mark || (s_text_byte == 8'd0);
        c         = cls.endf ? 8'd0 : s_text_byte;
        cls.ch    = c;
        cls.ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
        cls.dig   = (c >= CH_ZERO) && (c <= CH_NINE);
        cls.lower = (c >= CH_LA) && (c <= CH_LZ);
        cls.hexv  = cls.dig || ((c >= CH_UA) && (c <= CH_UF)) ||
                    ((c >= CH_LA) && (c <= CH_LF_));
        cls.hexd  = cls.dig ? c[3:0] : (c[3:0] + 4'd9);
    end

    assign s_ready    = (cnt_reg != 2'd2);
    assign push       = s_valid && s_ready;
    assign head       = slot_reg[rptr_reg];
    assign head_valid = (cnt_reg != 2'd0);

    always_comb begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = head_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, head_pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// File: rtl/jvt_back.sv
// ----------------------------------------------------------------------------
// jvt_back
// grammar engine: one beat per cycle given out_room, up to two result beats, container stack
// ----------------------------------------------------------------------------
module jvt_back #(
    parameter int MAX_DEPTH = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  jvt_pkg::item_t item,
    input  logic           item_valid,
    output logic           item_pop,
    input  logic           out_room,
    output jvt_pkg::res_t  res0,
    output jvt_pkg::res_t  res1,
    output logic           wr0,
    output logic           wr1
);
    import jvt_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef enum logic [3:0] {
        PH_TOP, PH_AFTER_TOP, PH_VALUE, PH_ARR_FIRST, PH_OBJ_FIRST, PH_KEY,
        PH_COLON, PH_AFTER_VAL, PH_STR, PH_ESC, PH_UHEX, PH_NUM_SIGN, PH_NUM,
        PH_LIT
    } ph_t;

    typedef enum logic [2:0] {
        NP_IDLE, NP_ZERO, NP_INT, NP_FRAC0, NP_FRAC, NP_EXP0, NP_EXPS, NP_EXP
    } np_t;

    typedef enum logic [1:0] {LK_NONE, LK_TRUE, LK_FALSE, LK_NULL} lk_t;

    function automatic logic [7:0] lit_char(lk_t k, logic [2:0] p);
        logic [7:0] r;
        r = 8'd0;
        case (k)
            LK_TRUE: begin
                case (p)
                    3'd1:    r = CH_LR;
                    3'd2:    r = CH_LU;
                    3'd3:    r = CH_LE;
                    default: r = 8'd0;
                endcase
            end
            LK_FALSE: begin
                case (p)
                    3'd1:    r = CH_LA;
                    3'd2:    r = CH_LL;
                    3'd3:    r = CH_LS;
                    3'd4:    r = CH_LE;
                    default: r = 8'd0;
                endcase
            end
            LK_NULL: begin
                case (p)
                    3'd1:    r = CH_LU;
                    3'd2:    r = CH_LL;
                    3'd3:    r = CH_LL;
                    default: r = 8'd0;
                endcase
            end
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    ph_t             ph_reg, ph_next;
    np_t             np_reg, np_next;
    lk_t             lk_reg, lk_next;
    logic [2:0]      lpos_reg, lpos_next;
    logic [15:0]     acc_reg, acc_next;
    logic [1:0]      hcnt_reg, hcnt_next;
    logic            key_reg, key_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic            top_reg, top_next;
    logic [31:0]     cnt_reg, cnt_next;
    logic            below_reg;
    logic            stk_mem [2**AW];

    logic            a_v, b_v, newdoc, push, push_obj, run, do_sv, do_open;
    logic            do_close, close_obj, top_obj;
    logic [3:0]      a_ev, a_err, b_ev, b_err;
    logic [7:0]      a_data, b_data, c;
    logic            a_key, b_key;
    logic [DW-1:0]   dn;
    ph_t             sph, vd;
    logic [15:0]     acc_sh;
    logic [AW-1:0]   rd_idx;

    assign item_pop = item_valid && out_room;
    assign c        = item.ch;
    assign top_obj  = (depth_reg != '0) && top_reg;
    assign vd       = (depth_reg != '0) ? PH_AFTER_VAL : PH_AFTER_TOP;
    assign acc_sh   = {acc_reg[11:0], item.hexd};

    always_comb begin
        ph_next   = ph_reg;
        np_next   = np_reg;
        lk_next   = lk_reg;
        lpos_next = lpos_reg;
        acc_next  = acc_reg;
        hcnt_next = hcnt_reg;
        key_next  = key_reg;
        top_next  = top_reg;
        a_v = 1'b0; a_ev = EV_ERROR; a_data = 8'd0; a_key = 1'b0; a_err = ER_NONE;
        b_v = 1'b0; b_ev = EV_ERROR; b_data = 8'd0; b_key = 1'b0; b_err = ER_NONE;
        newdoc = 1'b0; push = 1'b0; push_obj = 1'b0;
        run = 1'b0; sph = ph_reg;
        do_sv = 1'b0; do_open = 1'b0; do_close = 1'b0; close_obj = 1'b0;
        dn = depth_reg;

        unique case (ph_reg)
            PH_STR: begin
                if (item.endf) begin
                    a_v = 1'b1; a_err = ER_EARLY_END; newdoc = 1'b1;
                end else if (c < CH_SPACE) begin
                    a_v = 1'b1; a_err = ER_CONTROL; newdoc = 1'b1;
                end else if (c == CH_QUOTE) begin
                    a_v = 1'b1; a_ev = EV_STR_CLOSE; a_key = key_reg;
                    if (key_reg) begin
                        key_next = 1'b0;
                        ph_next  = PH_COLON;
                    end else begin
                        ph_next = vd;
                    end
                end else if (c == CH_BSLASH) begin
                    ph_next = PH_ESC;
                end else begin
                    a_v = 1'b1; a_ev = EV_STR_BYTE; a_data = c; a_key = key_reg;
                end
            end
            PH_ESC: begin
                if (item.endf) begin
                    a_v = 1'b1; a_err = ER_EARLY_END; newdoc = 1'b1;
                end else begin
                    a_v = 1'b1; a_ev = EV_STR_BYTE; a_key = key_reg; ph_next = PH_STR;
                    case (c) inside
                        CH_QUOTE, CH_BSLASH, CH_SLASH: a_data = c;
                        CH_LB:  a_data = CH_BS_CODE;
                        CH_LF_: a_data = CH_FF_CODE;
                        CH_LN:  a_data = CH_LF;
                        CH_LR:  a_data = CH_CR;
                        CH_LT:  a_data = CH_TAB;
                        CH_LU: begin
                            a_v = 1'b0; acc_next = 16'd0; hcnt_next = 2'd0;
                            ph_next = PH_UHEX;
                        end
                        default: begin
                            a_ev = EV_ERROR; a_key = 1'b0; a_err = ER_BAD_ESC;
                            newdoc = 1'b1;
                        end
                    endcase
                end
            end
            PH_UHEX: begin
                if (item.endf) begin
                    a_v = 1'b1; a_err = ER_EARLY_END; newdoc = 1'b1;
                end else if (!item.hexv) begin
                    a_v = 1'b1; a_err = ER_BAD_ESC; newdoc = 1'b1;
                end else begin
                    acc_next = acc_sh;
                    if (hcnt_reg == 2'd3) begin
                        hcnt_next = 2'd0;
                        if (acc_sh[15:7] != 9'd0) begin
                            a_v = 1'b1; a_err = ER_UNICODE; newdoc = 1'b1;
                        end else begin
                            a_v = 1'b1; a_ev = EV_STR_BYTE; a_data = acc_sh[7:0];
                            a_key = key_reg; ph_next = PH_STR;
                        end
                    end else begin
                        hcnt_next = hcnt_reg + 2'd1;
                    end
                end
            end
            PH_NUM_SIGN: begin
                if (!item.dig) begin
                    a_v = 1'b1; a_err = ER_BAD_NUM; newdoc = 1'b1;
                end else begin
                    a_v = 1'b1; a_ev = EV_NUM_CHAR; a_data = c; ph_next = PH_NUM;
                    np_next = (c == CH_ZERO) ? NP_ZERO : NP_INT;
                end
            end
            PH_NUM: begin
                unique case (np_reg)
                    NP_ZERO, NP_INT, NP_FRAC: begin
                        if (item.dig) begin
                            if (np_reg == NP_ZERO) begin
                                a_v = 1'b1; a_err = ER_BAD_NUM; newdoc = 1'b1;
                            end else begin
                                a_v = 1'b1; a_ev = EV_NUM_CHAR; a_data = c;
                            end
                        end else if ((c == CH_DOT) && (np_reg != NP_FRAC)) begin
                            a_v = 1'b1; a_ev = EV_NUM_CHAR; a_data = c; np_next = NP_FRAC0;
                        end else if ((c == CH_LE) || (c == CH_UE)) begin
                            a_v = 1'b1; a_ev = EV_NUM_CHAR; a_data = c; np_next = NP_EXP0;
                        end else begin
                            run = 1'b1;
                        end
                    end
                    NP_FRAC0: begin
                        if (item.dig) begin
                            a_v = 1'b1; a_ev = EV_NUM_CHAR; a_data = c; np_next = NP_FRAC;
                        end else begin
                            a_v = 1'b1; a_err = ER_BAD_NUM; newdoc = 1'b1;
                        end
                    end
                    NP_EXP0: begin
                        if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                            a_v = 1'b1; a_ev = EV_NUM_CHAR; a_data = c; np_next = NP_EXPS;
                        end else if (item.dig) begin
                            a_v = 1'b1; a_ev = EV_NUM_CHAR; a_data = c; np_next = NP_EXP;
                        end else begin
                            a_v = 1'b1; a_err = ER_BAD_NUM; newdoc = 1'b1;
                        end
                    end
                    NP_EXPS: begin
                        if (item.dig) begin
                            a_v = 1'b1; a_ev = EV_NUM_CHAR; a_data = c; np_next = NP_EXP;
                        end else begin
                            a_v = 1'b1; a_err = ER_BAD_NUM; newdoc = 1'b1;
                        end
                    end
                    NP_EXP: begin
                        if (item.dig) begin
                            a_v = 1'b1; a_ev = EV_NUM_CHAR; a_data = c;
                        end else begin
                            run = 1'b1;
                        end
                    end
                    default: begin
                        a_v = 1'b1; a_err = ER_BAD_NUM; newdoc = 1'b1;
                    end
                endcase
                if (run) begin
                    a_v = 1'b1; a_ev = EV_NUM_END; np_next = NP_IDLE; sph = vd;
                end
            end
            PH_LIT: begin
                if (lk_reg == LK_NONE) begin
                    a_v = 1'b1; a_err = ER_BAD_LIT; newdoc = 1'b1;
                end else if (lpos_reg < ((lk_reg == LK_FALSE) ? 3'd5 : 3'd4)) begin
                    if (!item.endf && (c == lit_char(lk_reg, lpos_reg))) begin
                        lpos_next = lpos_reg + 3'd1;
                    end else begin
                        a_v = 1'b1; a_err = ER_BAD_LIT; newdoc = 1'b1;
                    end
                end else if (item.lower) begin
                    a_v = 1'b1; a_err = ER_BAD_LIT; newdoc = 1'b1;
                end else begin
                    a_v = 1'b1;
                    case (lk_reg)
                        LK_TRUE:  a_ev = EV_TRUE;
                        LK_FALSE: a_ev = EV_FALSE;
                        default:  a_ev = EV_NULL;
                    endcase
                    lk_next = LK_NONE; lpos_next = 3'd0;
                    sph = vd; run = 1'b1;
                end
            end
            default: begin
                run = 1'b1;
            end
        endcase

        if (run) begin
            ph_next = sph;
            if (item.endf) begin
                b_v = 1'b1; newdoc = 1'b1;
                if (sph == PH_AFTER_TOP) begin
                    b_ev = EV_DOC_OK;
                end else begin
                    b_err = ER_EARLY_END;
                end
            end else if (!item.ws) begin
                unique case (sph)
                    PH_TOP, PH_VALUE: do_sv = 1'b1;
                    PH_AFTER_TOP: begin
                        b_v = 1'b1; b_err = ER_TRAILING; newdoc = 1'b1;
                    end
                    PH_ARR_FIRST: begin
                        if (c == CH_RBRACK) begin
                            do_close = 1'b1;
                        end else begin
                            do_sv = 1'b1;
                        end
                    end
                    PH_OBJ_FIRST, PH_KEY: begin
                        if ((sph == PH_OBJ_FIRST) && (c == CH_RBRACE)) begin
                            do_close = 1'b1; close_obj = 1'b1;
                        end else if (c == CH_QUOTE) begin
                            key_next = 1'b1; b_v = 1'b1; b_ev = EV_STR_OPEN;
                            b_key = 1'b1; ph_next = PH_STR;
                        end else begin
                            b_v = 1'b1; b_err = ER_BAD_CHAR; newdoc = 1'b1;
                        end
                    end
                    PH_COLON: begin
                        if (c == CH_COLON) begin
                            ph_next = PH_VALUE;
                        end else begin
                            b_v = 1'b1; b_err = ER_BAD_CHAR; newdoc = 1'b1;
                        end
                    end
                    default: begin
                        if (c == CH_COMMA) begin
                            ph_next = top_obj ? PH_KEY : PH_VALUE;
                        end else if (top_obj && (c == CH_RBRACE)) begin
                            do_close = 1'b1; close_obj = 1'b1;
                        end else if (!top_obj && (c == CH_RBRACK)) begin
                            do_close = 1'b1;
                        end else begin
                            b_v = 1'b1; b_err = ER_BAD_CHAR; newdoc = 1'b1;
                        end
                    end
                endcase
            end

            if (do_sv) begin
                if (c == CH_QUOTE) begin
                    key_next = 1'b0; b_v = 1'b1; b_ev = EV_STR_OPEN; ph_next = PH_STR;
                end else if (c == CH_MINUS) begin
                    b_v = 1'b1; b_ev = EV_NUM_CHAR; b_data = c; ph_next = PH_NUM_SIGN;
                end else if (item.dig) begin
                    b_v = 1'b1; b_ev = EV_NUM_CHAR; b_data = c; ph_next = PH_NUM;
                    np_next = (c == CH_ZERO) ? NP_ZERO : NP_INT;
                end else if ((c == CH_LBRACE) || (c == CH_LBRACK)) begin
                    do_open = 1'b1;
                end else if (c == CH_LT) begin
                    lk_next = LK_TRUE; lpos_next = 3'd1; ph_next = PH_LIT;
                end else if (c == CH_LF_) begin
                    lk_next = LK_FALSE; lpos_next = 3'd1; ph_next = PH_LIT;
                end else if (c == CH_LN) begin
                    lk_next = LK_NULL; lpos_next = 3'd1; ph_next = PH_LIT;
                end else if (item.lower) begin
                    b_v = 1'b1; b_err = ER_BAD_LIT; newdoc = 1'b1;
                end else begin
                    b_v = 1'b1; b_err = ER_BAD_CHAR; newdoc = 1'b1;
                end
            end

            if (do_open) begin
                if (depth_reg >= DW'(MAX_DEPTH)) begin
                    b_v = 1'b1; b_err = ER_TOO_DEEP; newdoc = 1'b1;
                end else begin
                    push = 1'b1; push_obj = (c == CH_LBRACE);
                    top_next = push_obj;
                    dn = depth_reg + DW'(1);
                    b_v = 1'b1;
                    b_ev = push_obj ? EV_OBJ_OPEN : EV_ARR_OPEN;
                    ph_next = push_obj ? PH_OBJ_FIRST : PH_ARR_FIRST;
                end
            end

            if (do_close) begin
                if (depth_reg != '0) begin
                    dn = depth_reg - DW'(1); top_next = below_reg;
                end
                b_v = 1'b1;
                b_ev = close_obj ? EV_OBJ_CLOSE : EV_ARR_CLOSE;
                ph_next = (dn != '0) ? PH_AFTER_VAL : PH_AFTER_TOP;
            end
        end

        depth_next = dn;
        cnt_next = (item.endf || (cnt_reg == 32'hFFFF_FFFF)) ? cnt_reg : cnt_reg + 32'd1;
        if (newdoc) begin
            ph_next    = PH_TOP;
            np_next    = NP_IDLE;
            lk_next    = LK_NONE;
            lpos_next  = 3'd0;
            acc_next   = 16'd0;
            hcnt_next  = 2'd0;
            key_next   = 1'b0;
            depth_next = '0;
            cnt_next   = 32'd0;
        end
    end

    always_comb begin
        res0.event_res   = a_v ? a_ev : b_ev;
        res0.data_byte   = a_v ? a_data : b_data;
        res0.is_key      = a_v ? a_key : b_key;
        res0.nest_level  = a_v ? 7'(depth_reg) : 7'(dn);
        res0.error_code  = a_v ? a_err : b_err;
        res0.byte_offset = cnt_reg;
        res0.last        = !(a_v && b_v);
        res1.event_res   = b_ev;
        res1.data_byte   = b_data;
        res1.is_key      = b_key;
        res1.nest_level  = 7'(dn);
        res1.error_code  = b_err;
        res1.byte_offset = cnt_reg;
        res1.last        = 1'b1;
    end

    assign wr0 = item_pop && (a_v || b_v);
    assign wr1 = item_pop && a_v && b_v;

    // entries below the top of stack live in memory, the top in a register
    assign rd_idx = AW'((item_pop ? depth_next : depth_reg) - DW'(2));

    always_ff @(posedge aclk) begin
        if (item_pop && push && (depth_reg != '0)) begin
            stk_mem[AW'(depth_reg - DW'(1))] <= top_reg;
        end
        if (item_pop && push) begin
            below_reg <= top_reg;
        end else begin
            below_reg <= stk_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg    <= PH_TOP;
            np_reg    <= NP_IDLE;
            lk_reg    <= LK_NONE;
            lpos_reg  <= 3'd0;
            acc_reg   <= 16'd0;
            hcnt_reg  <= 2'd0;
            key_reg   <= 1'b0;
            depth_reg <= '0;
            top_reg   <= 1'b0;
            cnt_reg   <= 32'd0;
        end else if (item_pop) begin
            ph_reg    <= ph_next;
            np_reg    <= np_next;
            lk_reg    <= lk_next;
            lpos_reg  <= lpos_next;
            acc_reg   <= acc_next;
            hcnt_reg  <= hcnt_next;
            key_reg   <= key_next;
            depth_reg <= depth_next;
            top_reg   <= top_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(MAX_DEPTH))
        else $error("nesting depth beyond limit");

    a_lit_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (ph_reg == PH_LIT) |-> (lk_reg != LK_NONE))
        else $error("literal phase without literal kind");

    a_num_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (ph_reg == PH_NUM) |-> (np_reg != NP_IDLE))
        else $error("number phase idle inside number");

    a_no_pop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pop |-> out_room)
        else $error("beat taken without result space");

endmodule

// File: rtl/jvt_outq.sv
// ----------------------------------------------------------------------------
// jvt_outq
// result queue: takes up to two beats per cycle, sends one per m_ready cycle
// ----------------------------------------------------------------------------
module jvt_outq (
    input  logic          aclk,
    input  logic          aresetn,
    input  jvt_pkg::res_t res0,
    input  jvt_pkg::res_t res1,
    input  logic          wr0,
    input  logic          wr1,
    output logic          room,
    output jvt_pkg::res_t m_res,
    output logic          m_valid,
    input  logic          m_ready
);
    import jvt_pkg::*;

    res_t       q_reg [4];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       rd;

    assign m_valid = (cnt_reg != 3'd0);
    assign m_res   = q_reg[rptr_reg];
    assign rd      = m_valid && m_ready;
    assign room    = (cnt_reg <= 3'd2);

    always_comb begin
        wptr_next = wptr_reg + {1'b0, wr0} + {1'b0, wr1};
        rptr_next = rptr_reg + {1'b0, rd};
        cnt_next  = cnt_reg + {2'b0, wr0} + {2'b0, wr1} - {2'b0, rd};
    end

    always_ff @(posedge aclk) begin
        if (wr0) begin
            q_reg[wptr_reg] <= res0;
        end
        if (wr1) begin
            q_reg[wptr_reg + 2'd1] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 2'd0;
            rptr_reg <= 2'd0;
            cnt_reg  <= 3'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("result queue overflow");

    a_wr_order: assert property (@(posedge aclk) disable iff (!aresetn)
        wr1 |-> wr0)
        else $error("second result without first");

endmodule

// File: rtl/json_validating_tokenizer.sv
// ----------------------------------------------------------------------------
// json_validating_tokenizer
// streaming json checker that turns text bytes into token event beats
// ----------------------------------------------------------------------------
// input channel s_*: one text byte per beat, or an end beat (s_end_mark set,
// or a zero byte). result channel m_*: token events, one or two per input
// beat (none inside a literal or escape, nor for whitespace, commas or colons
// that end no number or literal); m_last marks the final result of an input beat.
// a beat sits in a two-entry input queue, the grammar engine handles one
// beat per cycle while the result queue has room, and results wait in a
// four-entry queue, so the sustained rate is one byte per cycle while each
// beat yields at most one result and m_ready stays high; a beat with two
// results sends them on the result port one after the other.
// the container stack is a 2**clog2(MAX_DEPTH) x 1 memory with its top in a register.
// reset (aresetn low, synchronous) empties both queues and starts a new
// document at offset zero; a stalled m_ready fills the result queue and then
// drops s_ready, nothing is lost. after doc ok or error the next byte begins
// a new document.
// ----------------------------------------------------------------------------
module json_validating_tokenizer #(
    parameter int MAX_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_mark,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [3:0]  m_event_res,
    output logic [7:0]  m_data_byte,
    output logic        m_is_key,
    output logic [6:0]  m_nest_level,
    output logic [3:0]  m_error_code,
    output logic [31:0] m_byte_offset,
    output logic        m_last,
    output logic        m_valid,
    input  logic        m_ready
);
    import jvt_pkg::*;

    item_t head;
    logic  head_valid, head_pop, room, wr0, wr1;
    res_t  res0, res1, m_res;

    jvt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_text_byte (s_text_byte),
        .s_end_mark  (s_end_mark),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .head        (head),
        .head_valid  (head_valid),
        .head_pop    (head_pop)
    );

    jvt_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (head),
        .item_valid (head_valid),
        .item_pop   (head_pop),
        .out_room   (room),
        .res0       (res0),
        .res1       (res1),
        .wr0        (wr0),
        .wr1        (wr1)
    );

    jvt_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .res0    (res0),
        .res1    (res1),
        .wr0     (wr0),
        .wr1     (wr1),
        .room    (room),
        .m_res   (m_res),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

    assign m_event_res   = m_res.event_res;
    assign m_data_byte   = m_res.data_byte;
    assign m_is_key      = m_res.is_key;
    assign m_nest_level  = m_res.nest_level;
    assign m_error_code  = m_res.error_code;
    assign m_byte_offset = m_res.byte_offset;
    assign m_last        = m_res.last;

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the json validating tokenizer: a directed table of
// text beats, then randomly built documents (mostly well formed, some broken,
// some noise) with random idles on both channels. every accepted beat is run
// through a token predictor and every result beat is compared in order.
// ----------------------------------------------------------------------------
module tb;
    import jvt_pkg::*;

    localparam int DEPTH_MAX = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        P_TOP, P_AFTER_TOP, P_VALUE, P_ARR_FIRST, P_OBJ_FIRST, P_KEY, P_COLON,
        P_AFTER_VAL, P_STR, P_ESC, P_UHEX, P_NUM_SIGN, P_NUM, P_LIT
    } phase_e;

    typedef enum int {
        N_IDLE, N_ZERO, N_INT, N_DOT, N_FRAC, N_EXP, N_ESIGN, N_EDIG
    } num_e;

    typedef struct {
        logic [7:0] b;
        logic       e;
        bit         chk;
        logic [3:0] ev;
        logic [3:0] er;
    } row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic [7:0]  s_text_byte = 0;
    logic        s_end_mark = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [3:0]  m_event_res;
    logic [7:0]  m_data_byte;
    logic        m_is_key;
    logic [6:0]  m_nest_level;
    logic [3:0]  m_error_code;
    logic [31:0] m_byte_offset;
    logic        m_last;
    logic        m_valid;
    logic        m_ready = 0;

    json_validating_tokenizer #(.MAX_DEPTH(DEPTH_MAX)) dut (.*);

    // token predictor state
    phase_e      phase;
    bit          box_stack [DEPTH_MAX];
    int          depth;
    num_e        nphase;
    logic [15:0] uacc;
    int          hex_cnt;
    int          lit_kind;
    int          lit_pos;
    bit          key_on;
    logic [31:0] doc_bytes;
    logic [31:0] beat_off;
    int          beat_res;

    res_t        token_q [$];
    logic [7:0]  doc_q [$];
    int          errors = 0;
    int          cycles = 0;
    int          sent = 0;
    bit          hold_req = 0;

    initial begin
        forever begin
            #6 aclk = ~aclk;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report(input string msg);
        errors++;
        $display("mismatch @%0d: %s", cycles, msg);
    endtask

    function automatic void emit(logic [3:0] ev, logic [7:0] d, bit k, logic [3:0] er);
        res_t r;
        if (beat_res >= 2) return;
        r.event_res = ev;
        r.data_byte = d;
        r.is_key = k;
        r.nest_level = depth[6:0];
        r.error_code = er;
        r.byte_offset = beat_off;
        r.last = 0;
        token_q.insert(token_q.size(), r);
        beat_res++;
    endfunction

    function automatic void new_doc();
        phase = P_TOP;
        depth = 0;
        nphase = N_IDLE;
        uacc = 0;
        hex_cnt = 0;
        lit_kind = 0;
        lit_pos = 0;
        key_on = 0;
        doc_bytes = 0;
    endfunction

    function automatic void fail(logic [3:0] er);
        emit(EV_ERROR, 0, 0, er);
        new_doc();
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_ws(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic string lit_word(int k);
        return k == 1 ? "true" : (k == 2 ? "false" : "null");
    endfunction

    function automatic void value_done();
        phase = depth != 0 ? P_AFTER_VAL : P_AFTER_TOP;
    endfunction

    function automatic void open_box(bit obj);
        if (depth >= DEPTH_MAX) begin
            fail(ER_TOO_DEEP);
            return;
        end
        box_stack[depth] = obj;
        depth++;
        emit(obj ? EV_OBJ_OPEN : EV_ARR_OPEN, 0, 0, ER_NONE);
        phase = obj ? P_OBJ_FIRST : P_ARR_FIRST;
    endfunction

    function automatic void close_box(bit obj);
        if (depth > 0) depth--;
        emit(obj ? EV_OBJ_CLOSE : EV_ARR_CLOSE, 0, 0, ER_NONE);
        value_done();
    endfunction

    function automatic void open_string(bit k);
        key_on = k;
        emit(EV_STR_OPEN, 0, k, ER_NONE);
        phase = P_STR;
    endfunction

    function automatic void start_value(logic [7:0] c);
        if (c == CH_QUOTE) open_string(0);
        else if (c == CH_MINUS) begin
            emit(EV_NUM_CHAR, c, 0, ER_NONE);
            phase = P_NUM_SIGN;
        end else if (is_dig(c)) begin
            emit(EV_NUM_CHAR, c, 0, ER_NONE);
            phase = P_NUM;
            nphase = c == CH_ZERO ? N_ZERO : N_INT;
        end else if (c == CH_LBRACE) open_box(1);
        else if (c == CH_LBRACK) open_box(0);
        else if (c == CH_LT || c == CH_LF_ || c == CH_LN) begin
            lit_kind = c == CH_LT ? 1 : (c == CH_LF_ ? 2 : 3);
            lit_pos = 1;
            phase = P_LIT;
        end else if (c >= CH_LA && c <= CH_LZ) fail(ER_BAD_LIT);
        else fail(ER_BAD_CHAR);
    endfunction

    function automatic void structure(logic [7:0] c, bit fin);
        bit in_obj;
        if (fin) begin
            if (phase == P_AFTER_TOP) begin
                emit(EV_DOC_OK, 0, 0, ER_NONE);
                new_doc();
            end else fail(ER_EARLY_END);
            return;
        end
        if (is_ws(c)) return;
        case (phase)
            P_TOP, P_VALUE: start_value(c);
            P_AFTER_TOP: fail(ER_TRAILING);
            P_ARR_FIRST: if (c == CH_RBRACK) close_box(0); else start_value(c);
            P_OBJ_FIRST: begin
                if (c == CH_RBRACE) close_box(1);
                else if (c == CH_QUOTE) open_string(1);
                else fail(ER_BAD_CHAR);
            end
            P_KEY: if (c == CH_QUOTE) open_string(1); else fail(ER_BAD_CHAR);
            P_COLON: if (c == CH_COLON) phase = P_VALUE; else fail(ER_BAD_CHAR);
            default: begin
                in_obj = depth > 0 && box_stack[depth - 1];
                if (c == CH_COMMA) phase = in_obj ? P_KEY : P_VALUE;
                else if (in_obj && c == CH_RBRACE) close_box(1);
                else if (!in_obj && c == CH_RBRACK) close_box(0);
                else fail(ER_BAD_CHAR);
            end
        endcase
    endfunction

    function automatic int hex_of(logic [7:0] c);
        if (is_dig(c)) return int'(c - CH_ZERO);
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF_) return int'(c - CH_LA) + 10;
        return 16;
    endfunction

    function automatic void string_byte(logic [7:0] c);
        int h;
        logic [7:0] d;
        if (phase == P_STR) begin
            if (c < CH_SPACE) fail(ER_CONTROL);
            else if (c == CH_QUOTE) begin
                emit(EV_STR_CLOSE, 0, key_on, ER_NONE);
                if (key_on) begin
                    key_on = 0;
                    phase = P_COLON;
                end else value_done();
            end else if (c == CH_BSLASH) phase = P_ESC;
            else emit(EV_STR_BYTE, c, key_on, ER_NONE);
            return;
        end
        if (phase == P_ESC) begin
            case (c)
                CH_QUOTE, CH_BSLASH, CH_SLASH: d = c;
                CH_LB: d = CH_BS_CODE;
                CH_LF_: d = CH_FF_CODE;
                CH_LN: d = CH_LF;
                CH_LR: d = CH_CR;
                CH_LT: d = CH_TAB;
                CH_LU: begin
                    uacc = 0;
                    hex_cnt = 0;
                    phase = P_UHEX;
                    return;
                end
                default: begin
                    fail(ER_BAD_ESC);
                    return;
                end
            endcase
            emit(EV_STR_BYTE, d, key_on, ER_NONE);
            phase = P_STR;
            return;
        end
        h = hex_of(c);
        if (h > 15) begin
            fail(ER_BAD_ESC);
            return;
        end
        uacc = {uacc[11:0], h[3:0]};
        if (hex_cnt >= 3) begin
            hex_cnt = 0;
            if (uacc >= 128) begin
                fail(ER_UNICODE);
                return;
            end
            emit(EV_STR_BYTE, uacc[7:0], key_on, ER_NONE);
            phase = P_STR;
        end else hex_cnt++;
    endfunction

    function automatic void number_byte(logic [7:0] c, bit fin);
        bit dg, ech;
        dg = is_dig(c);
        ech = c == CH_LE || c == CH_UE;
        if (phase == P_NUM_SIGN) begin
            if (!dg) begin
                fail(ER_BAD_NUM);
                return;
            end
            emit(EV_NUM_CHAR, c, 0, ER_NONE);
            phase = P_NUM;
            nphase = c == CH_ZERO ? N_ZERO : N_INT;
            return;
        end
        case (nphase)
            N_ZERO, N_INT, N_FRAC: begin
                if (dg) begin
                    if (nphase == N_ZERO) fail(ER_BAD_NUM);
                    else emit(EV_NUM_CHAR, c, 0, ER_NONE);
                    return;
                end
                if (c == CH_DOT && nphase != N_FRAC) begin
                    emit(EV_NUM_CHAR, c, 0, ER_NONE);
                    nphase = N_DOT;
                    return;
                end
                if (ech) begin
                    emit(EV_NUM_CHAR, c, 0, ER_NONE);
                    nphase = N_EXP;
                    return;
                end
            end
            N_DOT: begin
                if (!dg) fail(ER_BAD_NUM);
                else begin
                    emit(EV_NUM_CHAR, c, 0, ER_NONE);
                    nphase = N_FRAC;
                end
                return;
            end
            N_EXP: begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                    emit(EV_NUM_CHAR, c, 0, ER_NONE);
                    nphase = N_ESIGN;
                end else if (!dg) fail(ER_BAD_NUM);
                else begin
                    emit(EV_NUM_CHAR, c, 0, ER_NONE);
                    nphase = N_EDIG;
                end
                return;
            end
            N_ESIGN: begin
                if (!dg) fail(ER_BAD_NUM);
                else begin
                    emit(EV_NUM_CHAR, c, 0, ER_NONE);
                    nphase = N_EDIG;
                end
                return;
            end
            N_EDIG: begin
                if (dg) begin
                    emit(EV_NUM_CHAR, c, 0, ER_NONE);
                    return;
                end
            end
            default: begin
                fail(ER_BAD_NUM);
                return;
            end
        endcase
        emit(EV_NUM_END, 0, 0, ER_NONE);
        nphase = N_IDLE;
        value_done();
        structure(c, fin);
    endfunction

    function automatic void literal_byte(logic [7:0] c, bit fin);
        string w;
        if (lit_kind == 0) begin
            fail(ER_BAD_LIT);
            return;
        end
        w = lit_word(lit_kind);
        if (lit_pos < w.len()) begin
            if (!fin && c == w[lit_pos]) lit_pos++;
            else fail(ER_BAD_LIT);
            return;
        end
        if (c >= CH_LA && c <= CH_LZ) begin
            fail(ER_BAD_LIT);
            return;
        end
        emit(lit_kind == 1 ? EV_TRUE : (lit_kind == 2 ? EV_FALSE : EV_NULL), 0, 0, ER_NONE);
        lit_kind = 0;
        lit_pos = 0;
        value_done();
        structure(c, fin);
    endfunction

    function automatic void tokenize(logic [7:0] b, logic e);
        bit fin;
        logic [7:0] c;
        fin = e || b == 0;
        c = fin ? 8'd0 : b;
        beat_res = 0;
        beat_off = doc_bytes;
        if (!fin && doc_bytes != 32'hFFFF_FFFF) doc_bytes++;
        if (phase == P_STR || phase == P_ESC || phase == P_UHEX) begin
            if (fin) fail(ER_EARLY_END); else string_byte(c);
        end else if (phase == P_NUM_SIGN || phase == P_NUM) number_byte(c, fin);
        else if (phase == P_LIT) literal_byte(c, fin);
        else structure(c, fin);
        if (beat_res > 0) token_q[$].last = 1;
    endfunction

    // input side
    task automatic send_beat(input logic [7:0] b, input logic e);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_text_byte <= b;
        s_end_mark <= e;
        do @(posedge aclk); while (!s_ready);
        tokenize(b, e);
        sent++;
    endtask

    // result side
    initial begin
        int n;
        res_t got, want;
        forever begin
            if (hold_req) begin
                m_ready <= 0;
                repeat (300) @(posedge aclk);
                hold_req = 0;
            end else begin
                n = $urandom_range(0, 4);
                if (n > 0) begin
                    m_ready <= 0;
                    repeat (n) @(posedge aclk);
                end
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
            got = '{m_event_res, m_data_byte, m_is_key, m_nest_level, m_error_code,
                    m_byte_offset, m_last};
            if (token_q.size() == 0) report($sformatf("unexpected beat %p", got));
            else begin
                want = token_q.pop_front();
                if (got !== want) report($sformatf("got %p want %p", got, want));
            end
        end
    end

    function automatic void put_byte(logic [7:0] v);
        doc_q.insert(doc_q.size(), v);
    endfunction

    function automatic logic [7:0] hex_char(int v);
        if (v < 10) return 8'(CH_ZERO + v);
        return 8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + v - 10);
    endfunction

    function automatic void add_ws();
        logic [7:0] w [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
        if ($urandom_range(0, 3) == 0) put_byte(w[$urandom_range(0, 3)]);
    endfunction

    function automatic void add_string();
        logic [7:0] esc [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LB, CH_LF_, CH_LN,
                                 CH_LR, CH_LT};
        logic [7:0] c;
        put_byte(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 5))
                0: put_byte(8'($urandom_range(128, 255)));
                1: begin
                    put_byte(CH_BSLASH);
                    put_byte(esc[$urandom_range(0, 7)]);
                end
                2: begin
                    put_byte(CH_BSLASH);
                    put_byte(CH_LU);
                    put_byte(CH_ZERO);
                    put_byte(CH_ZERO);
                    put_byte(hex_char($urandom_range(0, 7)));
                    put_byte(hex_char($urandom_range(0, 15)));
                end
                default: begin
                    do c = 8'($urandom_range(32, 126));
                    while (c == CH_QUOTE || c == CH_BSLASH);
                    put_byte(c);
                end
            endcase
        end
        put_byte(CH_QUOTE);
    endfunction

    function automatic void add_number();
        if ($urandom_range(0, 2) == 0) put_byte(CH_MINUS);
        if ($urandom_range(0, 3) == 0) put_byte(CH_ZERO);
        else begin
            put_byte(8'($urandom_range(CH_ZERO + 1, CH_NINE)));
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        if ($urandom_range(0, 2) == 0) begin
            put_byte(CH_DOT);
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        if ($urandom_range(0, 2) == 0) begin
            put_byte($urandom_range(0, 1) ? CH_LE : CH_UE);
            case ($urandom_range(0, 2))
                0: put_byte(CH_PLUS);
                1: put_byte(CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(1, 2)) put_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
    endfunction

    function automatic void add_value(int lvl);
        string w;
        int n;
        case ($urandom_range(0, lvl < 3 ? 5 : 2))
            0: add_string();
            1: add_number();
            2: begin
                w = lit_word($urandom_range(1, 3));
                foreach (w[i]) put_byte(w[i]);
            end
            3: begin
                put_byte(CH_LBRACK);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) put_byte(CH_COMMA);
                    add_ws();
                    add_value(lvl + 1);
                    add_ws();
                end
                put_byte(CH_RBRACK);
            end
            default: begin
                put_byte(CH_LBRACE);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) put_byte(CH_COMMA);
                    add_ws();
                    add_string();
                    add_ws();
                    put_byte(CH_COLON);
                    add_ws();
                    add_value(lvl + 1);
                end
                put_byte(CH_RBRACE);
            end
        endcase
    endfunction

    task automatic send_doc();
        foreach (doc_q[i]) send_beat(doc_q[i], 1'b0);
        if ($urandom_range(0, 1)) send_beat(8'($urandom_range(0, 255)), 1'b1);
        else send_beat(8'd0, 1'b0);
    endtask

    row_t dir_rows [$] = '{
        '{CH_LBRACK, 0, 1, EV_ARR_OPEN, ER_NONE},
        '{CH_LT, 0, 0, 0, 0}, '{CH_LR, 0, 0, 0, 0}, '{CH_LU, 0, 0, 0, 0},
        '{CH_LE, 0, 0, 0, 0},
        '{CH_RBRACK, 0, 1, EV_TRUE, ER_NONE},
        '{8'hA5, 1, 1, EV_DOC_OK, ER_NONE},
        '{CH_ZERO, 0, 0, 0, 0},
        '{CH_ZERO + 8'd1, 0, 1, EV_ERROR, ER_BAD_NUM},
        '{8'hFF, 0, 1, EV_ERROR, ER_BAD_CHAR},
        '{8'h78, 0, 1, EV_ERROR, ER_BAD_LIT},
        '{CH_QUOTE, 0, 0, 0, 0},
        '{8'h01, 0, 1, EV_ERROR, ER_CONTROL},
        '{CH_QUOTE, 0, 0, 0, 0}, '{CH_BSLASH, 0, 0, 0, 0},
        '{8'h71, 0, 1, EV_ERROR, ER_BAD_ESC},
        '{CH_QUOTE, 0, 0, 0, 0}, '{CH_BSLASH, 0, 0, 0, 0}, '{CH_LU, 0, 0, 0, 0},
        '{CH_ZERO, 0, 0, 0, 0}, '{CH_ZERO, 0, 0, 0, 0},
        '{CH_ZERO + 8'd8, 0, 0, 0, 0},
        '{CH_ZERO, 0, 1, EV_ERROR, ER_UNICODE},
        '{CH_ZERO + 8'd1, 0, 0, 0, 0},
        '{CH_SPACE, 0, 1, EV_NUM_END, ER_NONE},
        '{CH_ZERO + 8'd2, 0, 1, EV_ERROR, ER_TRAILING},
        '{8'd0, 0, 1, EV_ERROR, ER_EARLY_END}
    };

    initial begin
        int mode, pos;
        bit held, drained;
        held = 0;
        drained = 0;
        new_doc();
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].b, dir_rows[i].e);
            if (dir_rows[i].chk && (beat_res == 0 ||
                token_q[token_q.size() - beat_res].event_res !== dir_rows[i].ev ||
                token_q[token_q.size() - beat_res].error_code !== dir_rows[i].er))
                report($sformatf("directed row %0d does not match table", i));
        end

        // deepest legal nesting, then one level too deep
        doc_q.delete();
        repeat (DEPTH_MAX) put_byte(CH_LBRACK);
        repeat (DEPTH_MAX) put_byte(CH_RBRACK);
        send_doc();
        doc_q.delete();
        repeat (DEPTH_MAX + 1) put_byte(CH_LBRACK);
        send_doc();

        while (sent < 700) begin
            if (!held && sent > 350) begin
                hold_req = 1;
                held = 1;
            end
            if (!drained && sent > 550) begin
                drained = 1;
                s_valid <= 0;
                wait (token_q.size() == 0);
                @(posedge aclk);
            end
            mode = $urandom_range(0, 11);
            doc_q.delete();
            if (mode == 11) repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(1, 255)));
            else begin
                add_ws();
                add_value(0);
                add_ws();
                pos = $urandom_range(0, doc_q.size() - 1);
                if (mode == 8) doc_q[pos] = 8'($urandom_range(1, 255));
                else if (mode == 9) doc_q = doc_q[0:pos];
                else if (mode == 10) put_byte(8'($urandom_range(33, 126)));
            end
            send_doc();
        end
        s_valid <= 0;
        wait (token_q.size() == 0);
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: json_validating_tokenizer.f
rtl/jvt_pkg.sv
rtl/jvt_front.sv
rtl/jvt_back.sv
rtl/jvt_outq.sv
rtl/json_validating_tokenizer.sv
sim/tb.sv
